// ===== rtl/sli_pkg.sv =====
`default_nettype none

package sli_pkg;

  localparam int DefCapacity = 16;
  localparam int ValueW      = 32;
  localparam int CmdW        = 2;
  localparam int StatusW     = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED = 3'd0,
    ST_DELETED  = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4,
    ST_CLEARED  = 3'd5,
    ST_ENTRY    = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS0,
    S_DEL,
    S_DMP,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/sli_ram.sv =====
`default_nettype none

module sli_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sorted_list_insert_delete.sv =====
`default_nettype none

// Channel  Dir  tuser          tdata                       tlast
// s_axis   in   cmd [1:0]      value [31:0]                -
// m_axis   out  status [2:0]   entry_value, count, zeros   last
//
// One request at a time. Insert into an empty or a full list goes straight to the
// response; else each larger entry moves up one slot. Delete reads every stored entry.
// Clear, delete or dump of an empty list goes straight to the response.
// Dump: one RAM read per cycle while m_axis is not stalled.
// Reset empties the list at once; RAM contents are never cleared.
// A stalled m_axis holds the sequencer before it overwrites the output register.

module sorted_list_insert_delete #(
  parameter int Capacity = sli_pkg::DefCapacity,
  localparam int CntW     = $clog2(Capacity + 1),
  localparam int OutDataW = ((sli_pkg::ValueW + CntW + 7) / 8) * 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [sli_pkg::CmdW-1:0]   s_axis_tuser,  // cmd
  input  wire logic [sli_pkg::ValueW-1:0] s_axis_tdata,  // value
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [sli_pkg::StatusW-1:0]     m_axis_tuser,  // status
  output logic [OutDataW-1:0]             m_axis_tdata,  // entry_value, count, zero pad
  output logic                            m_axis_tlast   // last
);

  import sli_pkg::*;

  localparam int AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int PadW  = OutDataW - ValueW - CntW;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic                found_q, found_d;
  logic [ValueW-1:0]   val_q, val_d;
  status_e             status_q, status_d;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [ValueW-1:0]   out_value_q, out_value_d;
  logic [CntW-1:0]     out_count_q, out_count_d;
  logic                out_last_q, out_last_d;

  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  logic [ValueW-1:0]   ram_wdata, ram_rdata;

  logic                out_free;
  logic                in_req;
  logic [CntW-1:0]     last_idx;

  sli_ram #(
    .Width (ValueW),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign last_idx      = count_q - CntW'(1);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    found_d      = found_q;
    val_d        = val_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = val_q;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_req) begin
          val_d   = s_axis_tdata;
          found_d = 1'b0;
          state_d = S_RESP;
          unique case (cmd_e'(s_axis_tuser))
            CMD_INSERT: begin
              if (count_q == CntW'(Capacity)) begin
                status_d = ST_FULL;
              end else if (count_q == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = s_axis_tdata;
                count_d   = CntW'(1);
                status_d  = ST_INSERTED;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = last_idx[AddrW-1:0];
                idx_d     = count_q;
                state_d   = S_INS;
              end
            end
            CMD_DELETE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_d     = '0;
                state_d   = S_DEL;
              end
            end
            CMD_CLEAR: begin
              count_d  = '0;
              status_d = ST_CLEARED;
            end
            CMD_DUMP: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                val_d    = '0;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_d     = '0;
                state_d   = S_DMP;
              end
            end
            default: ;
          endcase
        end
      end

      // read data holds entries[idx-1]; move it up or drop the value in at idx
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AddrW-1:0];
        if ($signed(ram_rdata) >= $signed(val_q)) begin
          ram_wdata = ram_rdata;
          idx_d     = idx_q - CntW'(1);
          if (idx_q == CntW'(1)) begin
            state_d = S_INS0;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_q[AddrW-1:0] - AddrW'(2);
          end
        end else begin
          ram_wdata = val_q;
          count_d   = count_q + CntW'(1);
          status_d  = ST_INSERTED;
          state_d   = S_RESP;
        end
      end

      S_INS0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = val_q;
        count_d   = count_q + CntW'(1);
        status_d  = ST_INSERTED;
        state_d   = S_RESP;
      end

      // read data holds entries[idx]; once matched, every later entry moves down
      S_DEL: begin
        if (found_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q[AddrW-1:0] - AddrW'(1);
          ram_wdata = ram_rdata;
        end else if (ram_rdata == val_q) begin
          found_d = 1'b1;
        end
        if (idx_q == last_idx) begin
          state_d = S_RESP;
          if (found_d) begin
            count_d  = last_idx;
            status_d = ST_DELETED;
          end else begin
            status_d = ST_NOTFOUND;
          end
        end else begin
          idx_d     = idx_q + CntW'(1);
          ram_re    = 1'b1;
          ram_raddr = idx_q[AddrW-1:0] + AddrW'(1);
        end
      end

      S_DMP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_ENTRY;
          out_value_d  = ram_rdata;
          out_count_d  = count_q;
          out_last_d   = (idx_q == last_idx);
          if (idx_q == last_idx) begin
            state_d = S_IDLE;
          end else begin
            idx_d     = idx_q + CntW'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_q[AddrW-1:0] + AddrW'(1);
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_value_d  = val_q;
          out_count_d  = count_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    found_q      <= found_d;
    val_q        <= val_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {PadW'(0), out_count_q, out_value_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
